@@ rtl/core/bls_pkg.sv @@
// Shared types and constants for the line stepper.
// Used by the walker, the top level, the checker and the bench; depends on nothing else.
package bls_pkg;

  // Widths fixed by the stream fields and the window registers.
  localparam int FIELD_W        = 16;
  localparam int WIN_W          = 15;
  localparam int CFG_IDX_W      = 2;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [WIN_W-1:0] WIN_WIDTH_RST  = 15'd1024;
  localparam logic [WIN_W-1:0] WIN_HEIGHT_RST = 15'd768;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = 2'd1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_PIXEL  = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_e;

  // One input request as held in the input register.
  typedef struct packed {
    op_e                 opcode;
    logic [FIELD_W-1:0]  start_x;
    logic [FIELD_W-1:0]  start_y;
    logic [FIELD_W-1:0]  end_x;
    logic [FIELD_W-1:0]  end_y;
    logic [FIELD_W-1:0]  depth_tag;
  } item_t;

  // One result as held in the output register.
  typedef struct packed {
    kind_e               kind;
    logic [FIELD_W-1:0]  pixel_x;
    logic [FIELD_W-1:0]  pixel_y;
    logic                last_pixel;
    logic [FIELD_W-1:0]  pixel_tag;
  } result_t;

endpackage

@@ rtl/core/bls_stage.sv @@
// Pipeline register with a valid/ready handshake on both sides.
// Used for the input and the result register; depends on nothing else.
module bls_stage #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  // The register refills in the same cycle that its content is taken.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

@@ rtl/core/bls_walker.sv @@
// Segment state and the single-pass load/step logic of the line walker.
// Depends on bls_pkg; feeds the result register in the top level.
module bls_walker import bls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  item_t            item_i,
  input  logic [WIN_W-1:0] win_width_i,
  input  logic [WIN_W-1:0] win_height_i,
  output result_t          res_o
);

  localparam int CW = COORD_BITS;
  localparam int EW = CW + 1;
  localparam int KW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;

  logic [CW-1:0]      xi, yi, xf, yf;
  logic [KW-1:0]      xi_k, yi_k, xf_k, yf_k, lim_w, lim_h;
  logic [EW-1:0]      dx_e, dy_e, dx_mag, dy_mag;
  logic [CW-1:0]      ld_adx, ld_ady, ld_major;
  logic               ld_reject;

  logic [CW-1:0]      cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [EW-1:0]      err_q, err_d;
  logic [CW-1:0]      abs_dx_q, abs_dx_d, abs_dy_q, abs_dy_d;
  logic               x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic               major_x_q, major_x_d;
  logic [CW-1:0]      steps_q, steps_d;
  logic               busy_q, busy_d;
  logic [FIELD_W-1:0] tag_q, tag_d;

  logic [CW-1:0]      minor_v, major_v, nx, ny, steps_dec;
  logic [EW-1:0]      err_sum, err_step;
  logic               hit;
  logic [FIELD_W-1:0] px, py;

  // Coordinates are COORD_BITS-wide two's complement values.
  if (CW <= FIELD_W) begin : g_narrow_in
    assign xi = item_i.start_x[CW-1:0];
    assign yi = item_i.start_y[CW-1:0];
    assign xf = item_i.end_x[CW-1:0];
    assign yf = item_i.end_y[CW-1:0];
  end else begin : g_wide_in
    assign xi = {{(CW-FIELD_W){1'b0}}, item_i.start_x};
    assign yi = {{(CW-FIELD_W){1'b0}}, item_i.start_y};
    assign xf = {{(CW-FIELD_W){1'b0}}, item_i.end_x};
    assign yf = {{(CW-FIELD_W){1'b0}}, item_i.end_y};
  end

  if (CW >= FIELD_W) begin : g_wide_out
    assign px = nx[FIELD_W-1:0];
    assign py = ny[FIELD_W-1:0];
  end else begin : g_narrow_out
    assign px = {{(FIELD_W-CW){nx[CW-1]}}, nx};
    assign py = {{(FIELD_W-CW){ny[CW-1]}}, ny};
  end

  assign xi_k  = {{(KW-CW){xi[CW-1]}}, xi};
  assign yi_k  = {{(KW-CW){yi[CW-1]}}, yi};
  assign xf_k  = {{(KW-CW){xf[CW-1]}}, xf};
  assign yf_k  = {{(KW-CW){yf[CW-1]}}, yf};
  assign lim_w = {{(KW-WIN_W){1'b0}}, win_width_i};
  assign lim_h = {{(KW-WIN_W){1'b0}}, win_height_i};

  function automatic logic outside(input logic [KW-1:0] c, input logic [KW-1:0] lim);
    return c[KW-1] || ($signed(c) > $signed(lim));
  endfunction

  assign ld_reject = (outside(xi_k, lim_w) && outside(xf_k, lim_w)) ||
                     (outside(yi_k, lim_h) && outside(yf_k, lim_h));

  assign dx_e     = {xf[CW-1], xf} - {xi[CW-1], xi};
  assign dy_e     = {yf[CW-1], yf} - {yi[CW-1], yi};
  assign dx_mag   = dx_e[EW-1] ? (~dx_e + EW'(1)) : dx_e;
  assign dy_mag   = dy_e[EW-1] ? (~dy_e + EW'(1)) : dy_e;
  assign ld_adx   = dx_mag[CW-1:0];
  assign ld_ady   = dy_mag[CW-1:0];
  assign ld_major = (ld_adx >= ld_ady) ? ld_adx : ld_ady;

  // One step: the major axis always moves, the minor axis moves when the
  // accumulated error reaches the major delta.
  assign minor_v   = major_x_q ? abs_dy_q : abs_dx_q;
  assign major_v   = major_x_q ? abs_dx_q : abs_dy_q;
  assign err_sum   = err_q + {1'b0, minor_v};
  assign hit       = err_sum >= {1'b0, major_v};
  assign err_step  = hit ? (err_sum - {1'b0, major_v}) : err_sum;
  assign nx        = (major_x_q || hit) ?
                     (x_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1)) : cur_x_q;
  assign ny        = (!major_x_q || hit) ?
                     (y_neg_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1)) : cur_y_q;
  assign steps_dec = steps_q - CW'(1);

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    err_d     = err_q;
    abs_dx_d  = abs_dx_q;
    abs_dy_d  = abs_dy_q;
    x_neg_d   = x_neg_q;
    y_neg_d   = y_neg_q;
    major_x_d = major_x_q;
    steps_d   = steps_q;
    busy_d    = busy_q;
    tag_d     = tag_q;
    res_o     = '0;
    if (item_i.opcode == OP_LOAD) begin
      if (ld_reject) begin
        busy_d     = 1'b0;
        steps_d    = '0;
        res_o.kind = KIND_REJECT;
      end else begin
        cur_x_d         = xi;
        cur_y_d         = yi;
        x_neg_d         = dx_e[EW-1] || (dx_e == '0);
        y_neg_d         = dy_e[EW-1] || (dy_e == '0);
        abs_dx_d        = ld_adx;
        abs_dy_d        = ld_ady;
        major_x_d       = ld_adx >= ld_ady;
        err_d           = {2'b00, ld_major[CW-1:1]};
        steps_d         = ld_major;
        busy_d          = ld_major != '0;
        tag_d           = item_i.depth_tag;
        res_o.kind      = KIND_ACCEPT;
        res_o.pixel_tag = item_i.depth_tag;
      end
    end else if (busy_q) begin
      cur_x_d          = nx;
      cur_y_d          = ny;
      err_d            = err_step;
      steps_d          = steps_dec;
      busy_d           = steps_dec != '0;
      res_o.kind       = KIND_PIXEL;
      res_o.pixel_x    = px;
      res_o.pixel_y    = py;
      res_o.last_pixel = steps_dec == '0;
      res_o.pixel_tag  = tag_q;
    end else begin
      res_o.kind = KIND_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      err_q     <= '0;
      abs_dx_q  <= '0;
      abs_dy_q  <= '0;
      x_neg_q   <= 1'b0;
      y_neg_q   <= 1'b0;
      major_x_q <= 1'b0;
      steps_q   <= '0;
      busy_q    <= 1'b0;
      tag_q     <= '0;
    end else if (en_i) begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      err_q     <= err_d;
      abs_dx_q  <= abs_dx_d;
      abs_dy_q  <= abs_dy_d;
      x_neg_q   <= x_neg_d;
      y_neg_q   <= y_neg_d;
      major_x_q <= major_x_d;
      steps_q   <= steps_d;
      busy_q    <= busy_d;
      tag_q     <= tag_d;
    end
  end

endmodule

@@ rtl/core/bresenham_line_stepper.sv @@
// Channel  Dir  tuser        tlast       tdata (low bit first)
// s_axis   in   opcode       unused      start_x, start_y, end_x, end_y, depth_tag
// m_axis   out  kind         last_pixel  pixel_x, pixel_y, pixel_tag
// cfg      in   -            -           cfg_idx_i selects window_width / window_height
//
// One request per cycle is sustained while m_axis is ready; each request gives
// exactly one result. A request passes through the input register, then the
// walker logic into the result register. The walker state updates as a request moves on.
// A stalled m_axis holds the result register and backs up into the input
// register; s_axis_tready drops only when both are full.
// Reset is asynchronous and active low; it leaves the walker idle.
module bresenham_line_stepper import bls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [79:0]          s_axis_tdata,  // start_x, start_y, end_x, end_y, depth_tag
  input  logic                 s_axis_tuser,  // opcode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,  // pixel_x, pixel_y, pixel_tag
  output logic [1:0]           m_axis_tuser,  // kind
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WIN_W-1:0]     cfg_wdata_i
);

  item_t                s_item, q_item;
  logic [$bits(item_t)-1:0] q_item_bits;
  logic                 q_valid, res_ready;
  result_t              res, out_res;
  logic [$bits(result_t)-1:0] out_bits;
  logic [WIN_W-1:0]     win_width_q, win_height_q;

  assign s_item.opcode    = op_e'(s_axis_tuser);
  assign s_item.start_x   = s_axis_tdata[15:0];
  assign s_item.start_y   = s_axis_tdata[31:16];
  assign s_item.end_x     = s_axis_tdata[47:32];
  assign s_item.end_y     = s_axis_tdata[63:48];
  assign s_item.depth_tag = s_axis_tdata[79:64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_width_q  <= WIN_WIDTH_RST;
      win_height_q <= WIN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_WIN_WIDTH) begin
        win_width_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == REG_WIN_HEIGHT) begin
        win_height_q <= cfg_wdata_i;
      end
    end
  end

  bls_stage #(
    .WIDTH ($bits(item_t))
  ) u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_item),
    .out_valid_o (q_valid),
    .out_ready_i (res_ready),
    .out_data_o  (q_item_bits)
  );

  assign q_item = item_t'(q_item_bits);

  bls_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (q_valid && res_ready),
    .item_i       (q_item),
    .win_width_i  (win_width_q),
    .win_height_i (win_height_q),
    .res_o        (res)
  );

  bls_stage #(
    .WIDTH ($bits(result_t))
  ) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_bits)
  );

  assign out_res      = result_t'(out_bits);
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last_pixel;
  assign m_axis_tdata = {out_res.pixel_tag, out_res.pixel_y, out_res.pixel_x};

endmodule

@@ rtl/core/bls_checker.sv @@
// Port-level checks for the line stepper and the bind that attaches them.
// Depends on bls_pkg and on the bresenham_line_stepper ports.
module bls_checker import bls_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Only a pixel result carries coordinates or the last flag.
  a_no_pixel_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_PIXEL) |->
      (m_axis_tdata[31:0] == '0) && !m_axis_tlast)
    else $error("non-pixel result carries pixel fields");

  // Rejected and idle results carry no tag.
  a_no_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == KIND_REJECT) || (m_axis_tuser == KIND_IDLE)) |->
      (m_axis_tdata[47:32] == '0))
    else $error("rejected or idle result carries a tag");

  // No result comes out of reset.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind bresenham_line_stepper bls_checker u_bls_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the line stepper: segment loads and step requests
// go in on s_axis, every result on m_axis is checked against a local walker model.
// Depends on bls_pkg and the bresenham_line_stepper RTL.
module tb_top;
  import bls_pkg::*;

  localparam int PIPE_LAT   = 2;
  localparam int RAND_ITEMS = 1300;
  localparam int MAX_WALK   = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [79:0]          s_axis_tdata  = '0;  // start_x, start_y, end_x, end_y, depth_tag
  logic                 s_axis_tuser  = 1'b0;  // opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;  // pixel_x, pixel_y, pixel_tag
  logic [1:0]           m_axis_tuser;  // kind
  logic                 m_axis_tlast;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [WIN_W-1:0]     cfg_wdata_i   = '0;

  bresenham_line_stepper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Walker model state and window registers.
  logic [WIN_W-1:0]   win_w = WIN_WIDTH_RST;
  logic [WIN_W-1:0]   win_h = WIN_HEIGHT_RST;
  logic [FIELD_W-1:0] wk_x = '0, wk_y = '0, wk_adx = '0, wk_ady = '0, wk_left = '0;
  logic [FIELD_W-1:0] wk_tag = '0;
  logic [FIELD_W:0]   wk_err = '0;
  logic               wk_xneg = 1'b0, wk_yneg = 1'b0, wk_xmajor = 1'b0, wk_busy = 1'b0;

  result_t pending_results[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int errors    = 0;
  int n_sent    = 0;
  int n_accepts = 0;
  int n_rejects = 0;
  int n_pixels  = 0;
  int n_lasts   = 0;
  int n_idles   = 0;

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  function automatic bit off_window(input logic [FIELD_W-1:0] c, input logic [WIN_W-1:0] lim);
    int ci;
    ci = int'($signed(c));
    return (ci < 0) || (ci > int'(lim));
  endfunction

  function automatic logic [FIELD_W-1:0] clamp16(input int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[FIELD_W-1:0];
  endfunction

  // Advances the walker model by one request and returns the result it produces.
  function automatic result_t walker_result(input item_t req);
    result_t             res;
    logic signed [FIELD_W:0] dx, dy, mag_x, mag_y;
    logic [FIELD_W-1:0]  major;
    res = '0;
    if (req.opcode == OP_LOAD) begin
      if ((off_window(req.start_x, win_w) && off_window(req.end_x, win_w)) ||
          (off_window(req.start_y, win_h) && off_window(req.end_y, win_h))) begin
        wk_busy  = 1'b0;
        wk_left  = '0;
        res.kind = KIND_REJECT;
        return res;
      end
      dx        = $signed({req.end_x[FIELD_W-1], req.end_x}) -
                  $signed({req.start_x[FIELD_W-1], req.start_x});
      dy        = $signed({req.end_y[FIELD_W-1], req.end_y}) -
                  $signed({req.start_y[FIELD_W-1], req.start_y});
      mag_x     = (dx < 0) ? -dx : dx;
      mag_y     = (dy < 0) ? -dy : dy;
      wk_tag    = req.depth_tag;
      wk_x      = req.start_x;
      wk_y      = req.start_y;
      wk_xneg   = !(dx > 0);
      wk_yneg   = !(dy > 0);
      wk_adx    = mag_x[FIELD_W-1:0];
      wk_ady    = mag_y[FIELD_W-1:0];
      wk_xmajor = (wk_adx >= wk_ady);
      major     = wk_xmajor ? wk_adx : wk_ady;
      wk_err    = {1'b0, major >> 1};
      wk_left   = major;
      wk_busy   = (major != '0);
      res.kind      = KIND_ACCEPT;
      res.pixel_tag = wk_tag;
      return res;
    end
    if (!wk_busy) begin
      res.kind = KIND_IDLE;
      return res;
    end
    if (wk_xmajor) begin
      wk_x   = wk_xneg ? wk_x - FIELD_W'(1) : wk_x + FIELD_W'(1);
      wk_err = wk_err + {1'b0, wk_ady};
      if (wk_err >= {1'b0, wk_adx}) begin
        wk_err = wk_err - {1'b0, wk_adx};
        wk_y   = wk_yneg ? wk_y - FIELD_W'(1) : wk_y + FIELD_W'(1);
      end
    end else begin
      wk_y   = wk_yneg ? wk_y - FIELD_W'(1) : wk_y + FIELD_W'(1);
      wk_err = wk_err + {1'b0, wk_adx};
      if (wk_err >= {1'b0, wk_ady}) begin
        wk_err = wk_err - {1'b0, wk_ady};
        wk_x   = wk_xneg ? wk_x - FIELD_W'(1) : wk_x + FIELD_W'(1);
      end
    end
    wk_left = wk_left - FIELD_W'(1);
    if (wk_left == '0) wk_busy = 1'b0;
    res.kind       = KIND_PIXEL;
    res.pixel_x    = wk_x;
    res.pixel_y    = wk_y;
    res.last_pixel = !wk_busy;
    res.pixel_tag  = wk_tag;
    return res;
  endfunction

  function automatic item_t random_request();
    item_t req;
    req.opcode    = op_e'($urandom_range(1));
    req.start_x   = 16'($urandom);
    req.start_y   = 16'($urandom);
    req.end_x     = 16'($urandom);
    req.end_y     = 16'($urandom);
    req.depth_tag = 16'($urandom);
    return req;
  endfunction

  // A segment with at least one endpoint near the window, so most are drawn.
  function automatic item_t near_segment();
    item_t req;
    int    span, sx, sy;
    req        = random_request();
    req.opcode = OP_LOAD;
    span       = ($urandom_range(9) < 8) ? 12 : 200;
    sx         = int'($urandom_range(int'(win_w) + 32)) - 16;
    sy         = int'($urandom_range(int'(win_h) + 32)) - 16;
    req.start_x = clamp16(sx);
    req.start_y = clamp16(sy);
    req.end_x   = clamp16(int'($signed(req.start_x)) + int'($urandom_range(2 * span)) - span);
    req.end_y   = clamp16(int'($signed(req.start_y)) + int'($urandom_range(2 * span)) - span);
    return req;
  endfunction

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: kind %0d", m_axis_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", FIELD_W'(want.kind), FIELD_W'(m_axis_tuser));
        check_field("pixel_x", want.pixel_x, m_axis_tdata[15:0]);
        check_field("pixel_y", want.pixel_y, m_axis_tdata[31:16]);
        check_field("last_pixel", FIELD_W'(want.last_pixel), FIELD_W'(m_axis_tlast));
        check_field("pixel_tag", want.pixel_tag, m_axis_tdata[47:32]);
        case (want.kind)
          KIND_ACCEPT: n_accepts++;
          KIND_REJECT: n_rejects++;
          KIND_PIXEL:  n_pixels++;
          default:     n_idles++;
        endcase
        if (want.last_pixel) n_lasts++;
      end
    end
  end

  task automatic send_request(input item_t req);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.opcode;
    s_axis_tdata  <= {req.depth_tag, req.end_y, req.end_x, req.start_y, req.start_x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(walker_result(req));
    n_sent++;
  endtask

  task automatic send_load(input int sx, input int sy, input int ex, input int ey,
                           input logic [FIELD_W-1:0] tag);
    item_t req;
    req.opcode    = OP_LOAD;
    req.start_x   = 16'(sx);
    req.start_y   = 16'(sy);
    req.end_x     = 16'(ex);
    req.end_y     = 16'(ey);
    req.depth_tag = tag;
    send_request(req);
  endtask

  task automatic send_steps(input int count);
    item_t req;
    repeat (count) begin
      req        = random_request();
      req.opcode = OP_STEP;
      send_request(req);
    end
  endtask

  // Drops valid and waits until every request has come back through the pipeline.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WIN_WIDTH) win_w = val;
    else if (idx == REG_WIN_HEIGHT) win_h = val;
    @(posedge clk_i);
  endtask

  // Window reset values, idle steps and both ways of trivial rejection.
  task automatic test_reset_windows();
    send_steps(1);
    send_load(1024, 768, 1027, 766, 16'h0042);
    send_steps(4);
    send_load(1025, 0, 2000, 5, 16'h1111);
    send_load(5, -1, 6, 769, 16'h2222);
  endtask

  task automatic test_segment_cases();
    send_load(10, 10, 10, 10, 16'h1234);
    send_steps(1);
    send_load(20, 20, 18, 15, 16'h7fff);
    send_steps(6);
    send_load(0, 0, -32768, 32767, 16'h8000);
    send_steps(2);
    // Rejected load in the middle of a walk leaves the walker idle.
    send_load(-32768, -32768, 32767, 32767, 16'hffff);
    send_steps(1);
    send_load(32767, -32768, 0, 0, 16'h0000);
    send_steps(1);
    send_load(5, 5, 6, 5, 16'h5a5a);
    send_steps(1);
  endtask

  task automatic test_window_registers();
    settle_block();
    write_window(REG_WIN_WIDTH, 15'h7fff);
    write_window(REG_WIN_HEIGHT, 15'h7fff);
    send_load(-32768, 0, 32767, 0, 16'h0001);
    send_steps(2);
    settle_block();
    write_window(REG_WIN_WIDTH, 15'h0000);
    write_window(REG_WIN_HEIGHT, 15'h0000);
    send_load(0, 0, 5, -5, 16'h00ff);
    send_steps(1);
    send_load(1, 0, 2, 0, 16'h0f0f);
    settle_block();
    // Writes to the unused indexes must not touch either window edge.
    write_window(REG_SPARE_LO, 15'h7fff);
    write_window(REG_SPARE_HI, 15'h7fff);
    send_load(0, 1, 0, 2, 16'h3c3c);
    send_load(1, 0, 2, 0, 16'hc3c3);
  endtask

  task automatic test_random_traffic();
    int unsigned   src_mix[4];
    int unsigned   sink_mix[4];
    logic [WIN_W-1:0] w, h;
    int            goal, len, nsteps, pick;
    src_mix  = '{0, 53, 0, 38};
    sink_mix = '{0, 0, 53, 38};
    for (int ph = 0; ph < 4; ph++) begin
      for (int part = 0; part < 2; part++) begin
        settle_block();
        src_idle_pct   = src_mix[ph];
        sink_stall_pct = sink_mix[ph];
        case ($urandom_range(3))
          0: begin w = WIN_WIDTH_RST; h = WIN_HEIGHT_RST; end
          1: begin w = 15'h7fff; h = 15'h7fff; end
          2: begin w = 15'($urandom_range(40)); h = 15'($urandom_range(40)); end
          default: begin w = 15'($urandom); h = 15'($urandom); end
        endcase
        write_window(REG_WIN_WIDTH, w);
        write_window(REG_WIN_HEIGHT, h);
        goal = n_sent + RAND_ITEMS / 8;
        while (n_sent < goal) begin
          pick = $urandom_range(99);
          if (pick < 80) begin
            // Mostly whole walks; some are cut short by the next load.
            send_request(near_segment());
            len = int'(wk_left);
            if ($urandom_range(99) < 15) nsteps = $urandom_range(len);
            else nsteps = len + $urandom_range(2);
            if (nsteps > MAX_WALK) nsteps = MAX_WALK;
            send_steps(nsteps);
          end else if (pick < 90) begin
            send_load($urandom, $urandom, $urandom, $urandom, 16'($urandom));
            send_steps($urandom_range(3));
          end else begin
            send_request(random_request());
          end
        end
      end
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_windows();
    test_segment_cases();
    test_window_registers();
    test_random_traffic();
    settle_block();
    $display("Sent %0d requests over four idle/stall mixes and several window settings.",
             n_sent);
    $display("Results: %0d pixels (%0d segment ends), %0d accepted, %0d rejected, %0d idle.",
             n_pixels, n_lasts, n_accepts, n_rejects, n_idles);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
